// ===== design/iohist_pkg.sv =====
package iohist_pkg;

  // Default geometry and count width
  localparam int unsigned WIDTH_DEF      = 256;
  localparam int unsigned HEIGHT_DEF     = 128;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Beat field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned COL_W    = 8;
  localparam int unsigned ROW_W    = 7;
  localparam int unsigned VALUE_W  = 16;

  // Q4.28 orbit format
  localparam int unsigned Q_W    = 32;
  localparam int unsigned Q_FRAC = 28;
  localparam longint      Q_MAX  = 64'sh0000_0000_7fff_ffff;
  localparam longint      Q_MIN  = -Q_MAX - 64'sd1;

  // APB register file: one word per register
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-3:0] REG_VIEW_MODE = '0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ROLLOVER = 2'd0,
    ACT_ITERATE  = 2'd1,
    ACT_READ     = 2'd2
  } action_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
  } iohist_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] pixel_value;
    logic               hit_landed;
  } iohist_out_t;

  // Datapath step issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_READ_OWN,
    OP_ROLL,
    OP_VIEW,
    OP_MUL,
    OP_SUM,
    OP_SQ,
    OP_LAND,
    OP_HIT_READ,
    OP_HIT_WRITE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   push;
  } dp_cmd_t;

  typedef struct packed {
    logic                clr_last;
    logic                in_grid;
    logic [ACTION_W-1:0] action;
  } dp_sts_t;

endpackage

// ===== design/iohist_if.sv =====
interface iohist_in_if import iohist_pkg::*; ();
  logic       valid;
  logic       ready;
  iohist_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface iohist_out_if import iohist_pkg::*; ();
  logic        valid;
  logic        ready;
  iohist_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/iohist_ctrl.sv =====
module iohist_ctrl import iohist_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_ROLL,
    S_VIEW,
    S_MUL,
    S_SUM,
    S_SQ,
    S_LAND,
    S_HRD,
    S_HWR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   push;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign push   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NOP;
    cmd_o.push   = push;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        cmd_o.op = OP_READ_OWN;
        if (!sts_i.in_grid) begin
          state_d = S_DONE;
        end else begin
          unique case (action_e'(sts_i.action))
            ACT_ROLLOVER: state_d = S_ROLL;
            ACT_ITERATE:  state_d = S_MUL;
            ACT_READ:     state_d = S_VIEW;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_ROLL: begin
        cmd_o.op = OP_ROLL;
        state_d  = S_DONE;
      end
      S_VIEW: begin
        cmd_o.op = OP_VIEW;
        state_d  = S_DONE;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_SQ;
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = S_LAND;
      end
      S_LAND: begin
        cmd_o.op = OP_LAND;
        state_d  = S_HRD;
      end
      S_HRD: begin
        cmd_o.op = OP_HIT_READ;
        state_d  = S_HWR;
      end
      S_HWR: begin
        cmd_o.op = OP_HIT_WRITE;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (push) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/iohist_dp.sv =====
module iohist_dp import iohist_pkg::*; #(
  parameter int unsigned WIDTH      = WIDTH_DEF,
  parameter int unsigned HEIGHT     = HEIGHT_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  iohist_in_t  in_item_i,
  input  logic        view_mode_i,
  output iohist_out_t out_item_o
);

  localparam int unsigned NPIX   = WIDTH * HEIGHT;
  localparam int unsigned ADDR_W = $clog2(NPIX);
  localparam int unsigned LX_W   = $clog2(WIDTH);
  localparam int unsigned LY_W   = $clog2(HEIGHT);
  localparam int unsigned MAXB   = $clog2(((WIDTH > HEIGHT) ? WIDTH : HEIGHT) + 1);
  localparam int unsigned LAND_W = 36 + MAXB;
  localparam int unsigned PROD_W = 2 * Q_W;

  localparam longint ONE_Q = 64'sd1 <<< Q_FRAC;

  // Landing coordinates scaled by 4*2^28: s = v*WIDTH + 2*dim*2^28
  localparam logic signed [LAND_W-1:0] W_S    = LAND_W'(WIDTH);
  localparam logic signed [LAND_W-1:0] XOFS   = LAND_W'(2 * longint'(WIDTH) * ONE_Q);
  localparam logic signed [LAND_W-1:0] YOFS   = LAND_W'(2 * longint'(HEIGHT) * ONE_Q);
  localparam logic signed [LAND_W-1:0] XLIM   = LAND_W'(4 * longint'(WIDTH) * ONE_Q);
  localparam logic signed [LAND_W-1:0] YLIM   = LAND_W'(4 * longint'(HEIGHT) * ONE_Q);
  localparam logic [PROD_W-1:0]        ESC_LIM = PROD_W'(64'd1 << (2 * Q_FRAC + 2));

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX) begin
      r = Q_W'(Q_MAX);
    end else if (v < Q_MIN) begin
      r = Q_W'(Q_MIN);
    end else begin
      r = Q_W'(v);
    end
    return r;
  endfunction

  function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // c per column and per row, fixed at elaboration
  logic signed [Q_W-1:0] cre_tab [2**COL_W];
  logic signed [Q_W-1:0] cim_tab [2**ROW_W];

  for (genvar g = 0; g < 2**COL_W; g++) begin : g_cre
    localparam longint RAW = (4 * longint'(g) - 2 * longint'(WIDTH)) * ONE_Q
                             / longint'(WIDTH);
    assign cre_tab[g] = sat_q(RAW);
  end

  for (genvar g = 0; g < 2**ROW_W; g++) begin : g_cim
    localparam longint RAW = (4 * longint'(g) - 2 * longint'(HEIGHT)) * ONE_Q
                             / longint'(WIDTH);
    assign cim_tab[g] = sat_q(RAW);
  end

  // Pixel stores
  logic [2*Q_W-1:0]      orbit_mem  [NPIX];
  logic [COUNT_BITS-1:0] inside_mem [NPIX];
  logic [COUNT_BITS-1:0] hcur_mem   [NPIX];
  logic [COUNT_BITS-1:0] hprev_mem  [NPIX];

  logic [2*Q_W-1:0]      orbit_rd_q;
  logic [COUNT_BITS-1:0] inside_rd_q;
  logic [COUNT_BITS-1:0] hcur_rd_q;
  logic [COUNT_BITS-1:0] hprev_rd_q;

  logic [ADDR_W-1:0] clr_addr_q;
  logic [ADDR_W-1:0] p_q;
  logic [ADDR_W-1:0] q_q;
  logic [ACTION_W-1:0] action_q;
  logic              in_grid_q;
  logic signed [Q_W-1:0] cre_q, cim_q;
  logic signed [Q_W-1:0] nx_q, ny_q;
  logic signed [PROD_W-1:0] xx_q, yy_q, xy_q;
  logic signed [PROD_W-1:0] nx2_q, ny2_q;
  logic signed [LAND_W-1:0] xs_q, ys_q;
  logic [VALUE_W-1:0] res_value_q;
  logic               landed_q;
  iohist_out_t        out_q;

  logic [ADDR_W-1:0] own_addr;
  logic              own_in_grid;
  logic signed [Q_W-1:0] x, y;
  logic signed [PROD_W-1:0] diff, sum_re, sum_im;
  logic [PROD_W-1:0] sq_sum;
  logic              esc_in;
  logic              land_hit;
  logic [LX_W-1:0]   lx;
  logic [LY_W-1:0]   ly;
  logic [ADDR_W-1:0] land_addr;
  logic [COUNT_BITS-1:0] view_sel;
  logic [VALUE_W-1:0]    view_val;
  logic              own_rd;
  logic [ADDR_W-1:0] hcur_ra;
  logic              hcur_re;

  assign own_addr = ADDR_W'(in_item_i.row) * ADDR_W'(WIDTH) + ADDR_W'(in_item_i.col);
  assign own_in_grid = (32'(in_item_i.col) < WIDTH) && (32'(in_item_i.row) < HEIGHT);

  assign x = orbit_rd_q[2*Q_W-1:Q_W];
  assign y = orbit_rd_q[Q_W-1:0];

  // floor shifts are arithmetic right shifts
  assign diff   = xx_q - yy_q;
  assign sum_re = (diff >>> Q_FRAC) + PROD_W'(cre_q);
  assign sum_im = (xy_q >>> (Q_FRAC - 1)) + PROD_W'(cim_q);

  assign sq_sum = PROD_W'(nx2_q[PROD_W-2:0]) + PROD_W'(ny2_q[PROD_W-2:0]);
  assign esc_in = (sq_sum <= ESC_LIM);

  assign land_hit = !xs_q[LAND_W-1] && (xs_q != '0) && (xs_q < XLIM) &&
                    !ys_q[LAND_W-1] && (ys_q != '0) && (ys_q < YLIM);
  assign lx = xs_q[Q_FRAC+2 +: LX_W];
  assign ly = ys_q[Q_FRAC+2 +: LY_W];
  assign land_addr = ADDR_W'(ly) * ADDR_W'(WIDTH) + ADDR_W'(lx);

  assign view_sel = view_mode_i ? inside_rd_q : hprev_rd_q;

  if (COUNT_BITS > VALUE_W) begin : g_view_sat
    assign view_val = (|view_sel[COUNT_BITS-1:VALUE_W]) ? '1 : view_sel[VALUE_W-1:0];
  end else begin : g_view_ext
    assign view_val = VALUE_W'(view_sel);
  end

  // Write ports
  logic                  orbit_we, inside_we, hcur_we, hprev_we;
  logic [ADDR_W-1:0]     orbit_wa, inside_wa, hcur_wa, hprev_wa;
  logic [2*Q_W-1:0]      orbit_wd;
  logic [COUNT_BITS-1:0] inside_wd, hcur_wd, hprev_wd;

  always_comb begin
    orbit_we  = 1'b0;
    orbit_wa  = p_q;
    orbit_wd  = {nx_q, ny_q};
    inside_we = 1'b0;
    inside_wa = p_q;
    inside_wd = cnt_inc(inside_rd_q);
    hprev_we  = 1'b0;
    hprev_wa  = p_q;
    hprev_wd  = hcur_rd_q;
    hcur_we   = 1'b0;
    hcur_wa   = p_q;
    hcur_wd   = '0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        orbit_we  = 1'b1;
        orbit_wa  = clr_addr_q;
        orbit_wd  = '0;
        inside_we = 1'b1;
        inside_wa = clr_addr_q;
        inside_wd = '0;
        hprev_we  = 1'b1;
        hprev_wa  = clr_addr_q;
        hprev_wd  = '0;
        hcur_we   = 1'b1;
        hcur_wa   = clr_addr_q;
      end
      OP_ROLL: begin
        hprev_we = 1'b1;
        hcur_we  = 1'b1;
      end
      OP_SQ:        orbit_we = 1'b1;
      OP_LAND:      inside_we = esc_in;
      OP_HIT_WRITE: begin
        hcur_we = landed_q;
        hcur_wa = q_q;
        hcur_wd = cnt_inc(hcur_rd_q);
      end
      default: ;
    endcase
  end

  assign own_rd  = (cmd_i.op == OP_READ_OWN);
  assign hcur_re = own_rd || (cmd_i.op == OP_HIT_READ);
  assign hcur_ra = own_rd ? p_q : q_q;

  always_ff @(posedge clk_i) begin
    if (orbit_we) orbit_mem[orbit_wa] <= orbit_wd;
    if (own_rd)   orbit_rd_q <= orbit_mem[p_q];
  end

  always_ff @(posedge clk_i) begin
    if (inside_we) inside_mem[inside_wa] <= inside_wd;
    if (own_rd)    inside_rd_q <= inside_mem[p_q];
  end

  always_ff @(posedge clk_i) begin
    if (hprev_we) hprev_mem[hprev_wa] <= hprev_wd;
    if (own_rd)   hprev_rd_q <= hprev_mem[p_q];
  end

  always_ff @(posedge clk_i) begin
    if (hcur_we) hcur_mem[hcur_wa] <= hcur_wd;
    if (hcur_re) hcur_rd_q <= hcur_mem[hcur_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.op == OP_CLEAR) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        action_q    <= in_item_i.action;
        in_grid_q   <= own_in_grid;
        p_q         <= own_addr;
        cre_q       <= cre_tab[in_item_i.col];
        cim_q       <= cim_tab[in_item_i.row];
        res_value_q <= '0;
        landed_q    <= 1'b0;
      end
      OP_VIEW: res_value_q <= view_val;
      OP_MUL: begin
        xx_q <= x * x;
        yy_q <= y * y;
        xy_q <= x * y;
      end
      OP_SUM: begin
        nx_q <= sat_q(sum_re);
        ny_q <= sat_q(sum_im);
      end
      OP_SQ: begin
        nx2_q <= nx_q * nx_q;
        ny2_q <= ny_q * ny_q;
        xs_q  <= LAND_W'(nx_q) * W_S + XOFS;
        ys_q  <= LAND_W'(ny_q) * W_S + YOFS;
      end
      OP_LAND: begin
        landed_q <= land_hit;
        q_q      <= land_addr;
      end
      default: ;
    endcase
    if (cmd_i.push) begin
      out_q.pixel_value <= res_value_q;
      out_q.hit_landed  <= landed_q;
    end
  end

  assign sts_o.clr_last = (clr_addr_q == ADDR_W'(NPIX - 1));
  assign sts_o.in_grid  = in_grid_q;
  assign sts_o.action   = action_q;
  assign out_item_o     = out_q;

endmodule

// ===== design/incremental_orbit_histogram_top.sv =====
// Reset: asynchronous, active low. After reset a clearing pass zeroes every pixel store,
//   one pixel per cycle, WIDTH*HEIGHT pixels (32768 at default size); no beat is taken then.
// Each beat is loaded and its own pixel read; then rollover rolls the hit counts, read picks
//   the view value, and iterate multiplies, sums, squares, checks landing and updates the
//   landing pixel's hit count. Off-grid pixels and the unused action go straight to done,
//   which pushes once the output register is free. One item is processed at a time.
module incremental_orbit_histogram_top import iohist_pkg::*; #(
  parameter int unsigned WIDTH      = WIDTH_DEF,
  parameter int unsigned HEIGHT     = HEIGHT_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  iohist_in_if.sink             in_ch,
  iohist_out_if.source          out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------------------
  // Configuration: view_mode at byte address 0. Word index is paddr[top:2];
  // any other word reads zero and ignores writes. No wait states.
  // ---------------------------------------------------------------------------
  logic view_mode_q;
  logic cfg_wr;
  logic cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_VIEW_MODE);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_mode_q <= 1'b0;
    end else if (cfg_wr && cfg_hit) begin
      view_mode_q <= pwdata[0];
    end
  end

  assign prdata = cfg_hit ? APB_DATA_W'(view_mode_q) : '0;

  // ---------------------------------------------------------------------------
  // Controller: sequences clear pass, beat capture and the per-action steps.
  // Datapath: pixel stores, c tables, Q4.28 iterate arithmetic, landing math,
  // and the output register that lets a new beat in while a result waits.
  // ---------------------------------------------------------------------------
  dp_cmd_t     dp_cmd;
  dp_sts_t     dp_sts;
  iohist_out_t out_item;
  logic        in_ready;
  logic        out_valid;

  iohist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  iohist_dp #(
    .WIDTH      (WIDTH),
    .HEIGHT     (HEIGHT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .in_item_i   (in_ch.payload),
    .view_mode_i (view_mode_q),
    .out_item_o  (out_item)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  // ---------------------------------------------------------------------------
  // Checks. pend_q counts items taken but not yet delivered: at most one in
  // the output register plus one in flight.
  // ---------------------------------------------------------------------------
  logic       in_beat;
  logic       out_beat;
  logic [1:0] pend_q;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_beat) - 2'(out_beat);
    end
  end

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ch.ready)
    else $error("input ready right after a taken beat");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (pend_q != 2'd0))
    else $error("result valid with no item outstanding");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items outstanding");

  a_ready_one_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> (pend_q != 2'd2))
    else $error("ready while an unfinished item is in flight");

endmodule

// ===== bench/incremental_orbit_histogram_top_tb.sv =====
module incremental_orbit_histogram_top_tb;
  import iohist_pkg::*;

  localparam int unsigned W      = WIDTH_DEF;
  localparam int unsigned H      = HEIGHT_DEF;
  localparam int unsigned NPIX   = W * H;
  localparam int unsigned CNT_W  = COUNT_BITS_DEF;
  localparam longint      Q_ONE  = longint'(1) << Q_FRAC;
  // landing coordinates carry 4 * 2^28 of scale
  localparam int unsigned LAND_SH = Q_FRAC + 2;

  localparam logic [ACTION_W-1:0]   ACT_SPARE = 2'd3;
  localparam logic [APB_ADDR_W-1:0] VIEW_ADDR = {REG_VIEW_MODE, 2'b00};

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 240;
  localparam int HOT_N         = 8;
  localparam int SCRIPT_ROWS   = 24;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_e;

  // One line of the directed script; reps > 1 repeats the same beat.
  typedef struct packed {
    logic                set_view;
    logic                view;
    logic [ACTION_W-1:0] act;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [16:0]         reps;
    logic                typed;
    logic [VALUE_W-1:0]  value;
    logic                landed;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  iohist_in_if  in_ch ();
  iohist_out_if out_ch ();

  incremental_orbit_histogram_top i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow pixel stores; 2-state types start at zero like the cleared block.
  int              orbit_re   [NPIX];
  int              orbit_im   [NPIX];
  bit [CNT_W-1:0]  inside_cnt [NPIX];
  bit [CNT_W-1:0]  hits_cur   [NPIX];
  bit [CNT_W-1:0]  hits_prev  [NPIX];
  bit              view_sel;
  bit              land_seen;
  int unsigned     land_col;
  int unsigned     land_row;

  iohist_out_t     pixel_results_due [$];
  iohist_out_t     want_res;
  int              fail_count;
  int              cycle_count;

  // Sender burst shaping and receiver stall pattern
  int              burst_left;
  int              burst_max;
  int              gap_max;
  stall_e          stall_mode;
  int              stall_pct;
  int              stall_period;
  int              stall_duty;
  int              stall_tick;

  int unsigned     hot_col [HOT_N];
  int unsigned     hot_row [HOT_N];

  // Directed script. Typed results only where they are obvious.
  script_row_t op_script [SCRIPT_ROWS] = '{
    // fresh after reset: previous-frame count is zero
    '{1'b0, 1'b0, ACT_READ,     8'd0,   7'd0,   17'd1,     1'b1, 16'd0,     1'b0},
    // c = 0 at the center: z stays 0 and lands on its own pixel
    '{1'b0, 1'b0, ACT_ITERATE,  8'd128, 7'd64,  17'd1,     1'b1, 16'd0,     1'b1},
    '{1'b0, 1'b0, ACT_ROLLOVER, 8'd128, 7'd64,  17'd1,     1'b1, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_READ,     8'd128, 7'd64,  17'd1,     1'b1, 16'd1,     1'b0},
    '{1'b1, 1'b1, ACT_READ,     8'd128, 7'd64,  17'd1,     1'b1, 16'd1,     1'b0},
    // corner pixels: escape, then z runs into the format limits
    '{1'b0, 1'b0, ACT_ITERATE,  8'd0,   7'd0,   17'd5,     1'b0, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_ITERATE,  8'd255, 7'd127, 17'd1,     1'b0, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_ITERATE,  8'd255, 7'd0,   17'd3,     1'b0, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_ITERATE,  8'd0,   7'd127, 17'd3,     1'b0, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_READ,     8'd0,   7'd0,   17'd1,     1'b0, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_READ,     8'd255, 7'd127, 17'd1,     1'b0, 16'd0,     1'b0},
    // unused action code does nothing
    '{1'b0, 1'b0, ACT_SPARE,    8'd255, 7'd127, 17'd1,     1'b1, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_SPARE,    8'd0,   7'd0,   17'd1,     1'b1, 16'd0,     1'b0},
    // c = -1: period-two orbit through zero, then c = -i
    '{1'b0, 1'b0, ACT_ITERATE,  8'd64,  7'd64,  17'd4,     1'b0, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_ITERATE,  8'd128, 7'd0,   17'd2,     1'b0, 16'd0,     1'b0},
    // a run of steps at the center, both counts climb
    '{1'b0, 1'b0, ACT_ITERATE,  8'd128, 7'd64,  17'd40,    1'b0, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_READ,     8'd128, 7'd64,  17'd1,     1'b0, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_ROLLOVER, 8'd128, 7'd64,  17'd1,     1'b1, 16'd0,     1'b0},
    '{1'b1, 1'b0, ACT_READ,     8'd128, 7'd64,  17'd1,     1'b0, 16'd0,     1'b0},
    // hit count starts over after the rollover
    '{1'b0, 1'b0, ACT_ITERATE,  8'd128, 7'd64,  17'd1,     1'b1, 16'd0,     1'b1},
    '{1'b0, 1'b0, ACT_ROLLOVER, 8'd128, 7'd64,  17'd1,     1'b1, 16'd0,     1'b0},
    '{1'b0, 1'b0, ACT_READ,     8'd128, 7'd64,  17'd1,     1'b1, 16'd1,     1'b0},
    '{1'b0, 1'b0, ACT_READ,     8'd64,  7'd64,  17'd1,     1'b0, 16'd0,     1'b0},
    '{1'b1, 1'b1, ACT_READ,     8'd64,  7'd64,  17'd1,     1'b0, 16'd0,     1'b0}
  };

  function automatic longint sat_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint unsigned sq_mag(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    return m * m;
  endfunction

  function automatic bit [CNT_W-1:0] cnt_bump(bit [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Expected result of one beat; updates the shadow stores.
  function automatic iohist_out_t orbit_step(iohist_in_t it);
    iohist_out_t     res;
    int unsigned     p;
    int unsigned     q;
    longint          x, y, cre, cim, nx, ny, xs, ys;
    longint unsigned cnt;
    res = '0;
    if (it.col < W && it.row < H) begin
      p = it.row * W + it.col;
      case (it.action)
        ACT_ROLLOVER: begin
          hits_prev[p] = hits_cur[p];
          hits_cur[p]  = '0;
        end
        ACT_ITERATE: begin
          x   = orbit_re[p];
          y   = orbit_im[p];
          cre = sat_q((4 * longint'(it.col) - 2 * longint'(W)) * Q_ONE / longint'(W));
          cim = sat_q((4 * longint'(it.row) - 2 * longint'(H)) * Q_ONE / longint'(W));
          nx  = sat_q(((x * x - y * y) >>> Q_FRAC) + cre);
          ny  = sat_q(((x * y) >>> (Q_FRAC - 1)) + cim);
          orbit_re[p] = int'(nx);
          orbit_im[p] = int'(ny);
          if (sq_mag(nx) + sq_mag(ny) <= (64'd4 << (2 * Q_FRAC)))
            inside_cnt[p] = cnt_bump(inside_cnt[p]);
          xs = nx * longint'(W) + 2 * longint'(W) * Q_ONE;
          ys = ny * longint'(W) + 2 * longint'(H) * Q_ONE;
          if (xs > 0 && ys > 0 && xs < 4 * longint'(W) * Q_ONE &&
              ys < 4 * longint'(H) * Q_ONE) begin
            land_col = int'(xs >>> LAND_SH);
            land_row = int'(ys >>> LAND_SH);
            land_seen = 1'b1;
            q = land_row * W + land_col;
            hits_cur[q] = cnt_bump(hits_cur[q]);
            res.hit_landed = 1'b1;
          end
        end
        ACT_READ: begin
          cnt = view_sel ? inside_cnt[p] : hits_prev[p];
          res.pixel_value = (cnt > 65535) ? 16'hffff : cnt[VALUE_W-1:0];
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // Entered right after a rising edge; returns at the edge that took the beat.
  task automatic send_pixel_op(input logic [ACTION_W-1:0] act, input int unsigned col,
                               input int unsigned row, input bit typed,
                               input iohist_out_t typed_res);
    iohist_in_t  it;
    iohist_out_t res;
    int          gap;
    it.action = act;
    it.col    = col[COL_W-1:0];
    it.row    = row[ROW_W-1:0];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    res = orbit_step(it);
    pixel_results_due.push_back(typed ? typed_res : res);
  endtask

  // Block goes idle: nothing in flight, then a settling wait.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pixel_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of view_mode, then read it back.
  task automatic write_view(input bit v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VIEW_ADDR;
    pwdata  <= {{(APB_DATA_W-1){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    view_sel = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(APB_DATA_W-1){1'b0}}, v}) begin
      $error("view_mode readback: expected %0d, actual %0h", v, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_RANDOM:   out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      STALL_PERIODIC: out_ch.ready <= ((stall_tick % stall_period) >= stall_duty);
      default:        out_ch.ready <= 1'b1;
    endcase
  end

  // Result checker: in order against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pixel_results_due.size() == 0) begin
        $error("result beat with nothing expected: pixel_value %0d hit_landed %0d",
               out_ch.payload.pixel_value, out_ch.payload.hit_landed);
        fail_count++;
      end else begin
        want_res = pixel_results_due.pop_front();
        if (out_ch.payload.pixel_value !== want_res.pixel_value) begin
          $error("pixel_value: expected %0d, actual %0d",
                 want_res.pixel_value, out_ch.payload.pixel_value);
          fail_count++;
        end
        if (out_ch.payload.hit_landed !== want_res.hit_landed) begin
          $error("hit_landed: expected %0d, actual %0d",
                 want_res.hit_landed, out_ch.payload.hit_landed);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int          pick;
    int          h;
    int          k;
    int          items_sent;
    int unsigned lc;
    int unsigned lr;
    iohist_out_t typed_res;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_count    = 0;
    cycle_count   = 0;
    burst_left    = 0;
    burst_max     = 8;
    gap_max       = 4;
    stall_mode    = STALL_RANDOM;
    stall_pct     = 25;
    stall_period  = 5;
    stall_duty    = 1;
    stall_tick    = 0;
    view_sel      = 1'b0;
    land_seen     = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script; beats wait out the clearing pass on ready.
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (op_script[i].set_view) begin
        settle();
        write_view(op_script[i].view);
      end
      typed_res.pixel_value = op_script[i].value;
      typed_res.hit_landed  = op_script[i].landed;
      repeat (op_script[i].reps)
        send_pixel_op(op_script[i].act, op_script[i].col, op_script[i].row,
                      op_script[i].typed, typed_res);
    end

    // Random phases, each with its own view and idling profile
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_view((ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
      case (ph % 4)
        0: begin
          gap_max    = 0;
          burst_max  = 1;
          stall_mode <= STALL_NONE;
        end
        1: begin
          gap_max    = 3;
          burst_max  = 12;
          stall_pct  <= 30;
          stall_mode <= STALL_RANDOM;
        end
        2: begin
          gap_max      = 10;
          burst_max    = 3;
          stall_period <= 7;
          stall_duty   <= 3;
          stall_mode   <= STALL_PERIODIC;
        end
        default: begin
          gap_max    = $urandom_range(1, 8);
          burst_max  = $urandom_range(1, 16);
          stall_pct  <= 60;
          stall_mode <= STALL_RANDOM;
        end
      endcase
      // half the hot pixels near the set, where orbits stay bounded
      for (int j = 0; j < HOT_N; j++) begin
        if (j < HOT_N / 2) begin
          hot_col[j] = $urandom_range(64, 160);
          hot_row[j] = $urandom_range(32, 96);
        end else begin
          hot_col[j] = $urandom_range(0, W - 1);
          hot_row[j] = $urandom_range(0, H - 1);
        end
      end

      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        h    = $urandom_range(0, HOT_N - 1);
        if (pick < 45) begin
          // walk one orbit several steps
          k = $urandom_range(1, 4);
          repeat (k) send_pixel_op(ACT_ITERATE, hot_col[h], hot_row[h], 1'b0, '0);
          items_sent += k;
        end else if (pick < 58) begin
          send_pixel_op(ACT_ITERATE, $urandom_range(0, W - 1), $urandom_range(0, H - 1),
                        1'b0, '0);
          items_sent++;
        end else if (pick < 72 && land_seen) begin
          // close the frame where the last hit fell, then look at it
          lc = land_col;
          lr = land_row;
          send_pixel_op(ACT_ROLLOVER, lc, lr, 1'b0, '0);
          send_pixel_op(ACT_READ, lc, lr, 1'b0, '0);
          items_sent += 2;
        end else if (pick < 84) begin
          send_pixel_op(ACT_READ, hot_col[h], hot_row[h], 1'b0, '0);
          items_sent++;
        end else if (pick < 92) begin
          send_pixel_op(ACT_ROLLOVER, hot_col[h], hot_row[h], 1'b0, '0);
          items_sent++;
        end else if (pick < 97) begin
          send_pixel_op(ACT_READ, $urandom_range(0, W - 1), $urandom_range(0, H - 1),
                        1'b0, '0);
          items_sent++;
        end else begin
          send_pixel_op(ACT_SPARE, $urandom_range(0, W - 1), $urandom_range(0, H - 1),
                        1'b0, '0);
          items_sent++;
        end
      end
    end

    settle();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
